// ===== rtl/assert_macros.svh =====
// assertion macros included by indexed_ordered_list_top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/iol_pkg.sv =====
// types, codes and defaults for the indexed ordered list
`timescale 1ns / 1ps
package iol_pkg;
  localparam int CAPACITY_DEF   = 16;
  localparam int VALUE_BITS_DEF = 32;

  localparam logic [2:0] KIND_INSERT    = 3'd0;
  localparam logic [2:0] KIND_APPEND    = 3'd1;
  localparam logic [2:0] KIND_DELETE    = 3'd2;
  localparam logic [2:0] KIND_READ      = 3'd3;
  localparam logic [2:0] KIND_READ_TAIL = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_INS  = 2'd1;
  localparam logic [1:0] CELL_DEL  = 2'd2;

  typedef struct packed {
    logic [2:0]        kind;
    logic signed [7:0] position;
    logic [31:0]       handle;
  } in_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [1:0]  status;
    logic [4:0]  entry_count;
    logic        is_empty;
  } out_t;

  typedef struct packed {
    logic [1:0] op;
    logic       rd_en;
  } cell_ctrl_t;
endpackage

// ===== rtl/iol_cell.sv =====
// one list slot: shifts towards either neighbour and answers indexed reads
`timescale 1ns / 1ps
module iol_cell #(
  parameter int CELL_IDX   = 0,
  parameter int IDX_W      = 4,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  iol_pkg::cell_ctrl_t   ctrl,
  input  logic [IDX_W-1:0]      idx,
  input  logic [VALUE_BITS-1:0] value_in,
  input  logic [VALUE_BITS-1:0] prev_val,
  input  logic [VALUE_BITS-1:0] next_val,
  output logic [VALUE_BITS-1:0] val_o,
  output logic [VALUE_BITS-1:0] rd_o
);
  import iol_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [VALUE_BITS-1:0] slot_r;
  logic [VALUE_BITS-1:0] slot_nxt;

  always_comb begin
    slot_nxt = slot_r;
    case (ctrl.op)
      CELL_INS: begin
        if (MY_IDX == idx) begin
          slot_nxt = value_in;
        end else if (MY_IDX > idx) begin
          slot_nxt = prev_val;
        end
      end
      CELL_DEL: begin
        // entries at and above the deleted one take their upper neighbour
        if (MY_IDX >= idx) begin
          slot_nxt = next_val;
        end
      end
      default: slot_nxt = slot_r;
    endcase
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign val_o = slot_r;
  assign rd_o  = (ctrl.rd_en && (MY_IDX == idx)) ? slot_r : '0;
endmodule

// ===== rtl/indexed_ordered_list_top.sv =====
// indexed ordered list: decode, count and a chain of slot cells
// a result strobes on out_valid in the cycle after start is taken
// throughput: one transaction per cycle, busy is never raised
// every operation is applied across all cells in parallel
// reset clears the entry count and the result strobe; slots stay unwritten
// results cannot be stalled, so each one is shown for one cycle only
`timescale 1ns / 1ps
`include "assert_macros.svh"
module indexed_ordered_list_top #(
  parameter int CAPACITY   = iol_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = iol_pkg::VALUE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  iol_pkg::in_t  in_item,
  output logic          out_valid,
  output iol_pkg::out_t out_item
);
  import iol_pkg::*;

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int PW    = CW + 7;

  logic [CW-1:0]         count_r, count_nxt;
  logic                  out_valid_r;
  out_t                  out_r, out_nxt;
  logic [1:0]            status_nxt;
  cell_ctrl_t            ctrl;
  logic [IDX_W-1:0]      idx;
  logic [VALUE_BITS-1:0] value_in;
  logic [VALUE_BITS-1:0] vals  [CAPACITY];
  logic [VALUE_BITS-1:0] rds   [CAPACITY];
  logic [VALUE_BITS-1:0] rd_bus;
  logic                  accept;
  logic [PW-1:0]         pos_ext, cnt_ext, ins_pos;
  logic                  pos_neg, in_range, full;
  logic [CW-1:0]         cnt_m1;
  logic [VALUE_BITS+31:0] handle_wide;
  logic [VALUE_BITS+31:0] rd_wide;
  logic [CW+4:0]         cnt_wide;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign pos_neg     = in_item.position[7];
  assign pos_ext     = {{CW{1'b0}}, in_item.position[6:0]};
  assign cnt_ext     = {7'b0, count_r};
  assign in_range    = !pos_neg && (pos_ext < cnt_ext);
  assign full        = (count_r == CW'(CAPACITY));
  assign cnt_m1      = count_r - CW'(1);
  assign handle_wide = {{VALUE_BITS{1'b0}}, in_item.handle};
  assign value_in    = handle_wide[VALUE_BITS-1:0];

  always_comb begin
    ctrl.op    = CELL_HOLD;
    ctrl.rd_en = 1'b0;
    idx        = '0;
    count_nxt  = count_r;
    ins_pos    = '0;
    status_nxt = ST_DONE;
    case (in_item.kind)
      KIND_INSERT, KIND_APPEND: begin
        // negative insert positions clamp to the head
        if (in_item.kind == KIND_APPEND) begin
          ins_pos = cnt_ext;
        end else if (!pos_neg) begin
          ins_pos = pos_ext;
        end
        if (ins_pos > cnt_ext) begin
          status_nxt = ST_RANGE;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctrl.op   = CELL_INS;
          idx       = ins_pos[IDX_W-1:0];
          count_nxt = count_r + CW'(1);
        end
      end
      KIND_DELETE: begin
        if (in_range) begin
          ctrl.op   = CELL_DEL;
          idx       = pos_ext[IDX_W-1:0];
          count_nxt = cnt_m1;
        end else begin
          status_nxt = ST_RANGE;
        end
      end
      KIND_READ: begin
        if (in_range) begin
          ctrl.rd_en = 1'b1;
          idx        = pos_ext[IDX_W-1:0];
        end else begin
          status_nxt = ST_RANGE;
        end
      end
      KIND_READ_TAIL: begin
        if (count_r != '0) begin
          ctrl.rd_en = 1'b1;
          idx        = cnt_m1[IDX_W-1:0];
        end
      end
      default: ctrl.op = CELL_HOLD;
    endcase
    if (!accept) begin
      ctrl.op    = CELL_HOLD;
      ctrl.rd_en = 1'b0;
      count_nxt  = count_r;
    end
  end

  // only the addressed cell drives a non-zero read word
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_bus = rd_bus | rds[i];
    end
  end

  assign rd_wide  = {32'b0, rd_bus};
  assign cnt_wide = {5'b0, count_nxt};

  always_comb begin
    out_nxt.read_value  = rd_wide[31:0];
    out_nxt.status      = status_nxt;
    out_nxt.entry_count = cnt_wide[4:0];
    out_nxt.is_empty    = (count_nxt == '0);
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VALUE_BITS-1:0] prev_v, next_v;
    if (g == 0) begin : g_head
      assign prev_v = '0;
    end else begin : g_mid
      assign prev_v = vals[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign next_v = '0;
    end else begin : g_body
      assign next_v = vals[g+1];
    end
    iol_cell #(
      .CELL_IDX   (g),
      .IDX_W      (IDX_W),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .idx      (idx),
      .value_in (value_in),
      .prev_val (prev_v),
      .next_val (next_v),
      .val_o    (vals[g]),
      .rd_o     (rds[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `ASSERT_NEXT(a_accept_strobes, clk, rst_n, accept, out_valid)
  `ASSERT_NEXT(a_no_spurious_result, clk, rst_n, !accept, !out_valid)
  `ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(CAPACITY))
  `ASSERT_IMPLIES(a_full_means_full, clk, rst_n, out_valid && out_item.status == ST_FULL, count_r == CW'(CAPACITY))
  `ASSERT_IMPLIES(a_empty_reads_zero, clk, rst_n, out_valid && out_item.is_empty, out_item.read_value == '0)
  `ASSERT_IMPLIES(a_empty_flag, clk, rst_n, out_valid, out_item.is_empty == (count_r == '0))
endmodule
